// ----- rtl/core/motor_session_run_pause_control_macros.svh -----
// Assertion macros of the motor session run/pause control RTL.
`ifndef MOTOR_SESSION_RUN_PAUSE_CONTROL_MACROS_SVH
`define MOTOR_SESSION_RUN_PAUSE_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MSRPC_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msrpc: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define MSRPC_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msrpc: next-cycle check failed");

`endif

// ----- rtl/core/msrpc_pkg.sv -----
// Types and constants of the motor session run/pause control.
`timescale 1ns / 1ps

package msrpc_pkg;

  localparam int SPEED_W     = 18;
  localparam int POT_LEVEL_W = 12;
  localparam int THR_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THR    = 2'd2;

  localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = 18'd20000;
  localparam logic [THR_W-1:0]   RST_CHANGE_MIN = 8'd5;
  localparam logic [THR_W-1:0]   RST_RUN_THR    = 8'd4;

  typedef enum logic [1:0] {
    SES_IDLE   = 2'd0,
    SES_PAUSED = 2'd1,
    SES_RUN    = 2'd2
  } session_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_POT  = 2'd1,
    MODE_MAX  = 2'd2
  } run_mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_PAUSE = 2'd2,
    ACT_STOP  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ORG_POT    = 2'd0,
    ORG_SWITCH = 2'd1,
    ORG_UI     = 2'd2
  } origin_t;

  typedef struct packed {
    logic                   pot_valid;
    logic [POT_LEVEL_W-1:0] pot_level;
    logic                   footswitch_valid;
    logic                   footswitch_pressed;
    act_t                   kind;
  } item_t;

  typedef struct packed {
    session_t  state;
    run_mode_t mode;
    logic      start_p;
    logic      pause_p;
    logic      stop_p;
  } info_t;

endpackage

// ----- rtl/core/msrpc_ifs.sv -----
// Request channels of the motor session run/pause control.
`timescale 1ns / 1ps

interface msrpc_in_if;
  import msrpc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   pot_valid;
  logic [POT_LEVEL_W-1:0] pot_level;
  logic                   footswitch_valid;
  logic                   footswitch_pressed;
  logic [1:0]             kind;

  modport source (output valid, pot_valid, pot_level, footswitch_valid,
                  footswitch_pressed, kind, input ready);
  modport sink (input valid, pot_valid, pot_level, footswitch_valid,
                footswitch_pressed, kind, output ready);
endinterface

interface msrpc_out_if;
  import msrpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_command;
  logic [1:0]         session_state;
  logic [1:0]         run_mode;
  logic               start_pulse;
  logic               pause_pulse;
  logic               stop_pulse;

  modport source (output valid, speed_command, session_state, run_mode,
                  start_pulse, pause_pulse, stop_pulse, input ready);
  modport sink (input valid, speed_command, session_state, run_mode,
                start_pulse, pause_pulse, stop_pulse, output ready);
endinterface

interface msrpc_cfg_if;
  import msrpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/msrpc_tick.sv -----
// Session state, pot and footswitch edge tracking, and intent resolution per tick.
`timescale 1ns / 1ps

module msrpc_tick #(
  parameter int POT_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        apply,
  input  msrpc_pkg::item_t            item,
  input  logic [msrpc_pkg::THR_W-1:0] change_min,
  input  logic [msrpc_pkg::THR_W-1:0] run_thr,
  output logic [POT_BITS-1:0]         level_sel,
  output msrpc_pkg::info_t            info
);
  import msrpc_pkg::*;

  localparam int LW       = (POT_BITS > POT_LEVEL_W) ? POT_BITS : POT_LEVEL_W;
  localparam int FULL_INT = (1 << POT_BITS) - 1;
  localparam logic [LW-1:0]       FULL_EXT = LW'(FULL_INT);
  localparam logic [POT_BITS-1:0] FULL     = POT_BITS'(FULL_INT);

  session_t            mode_r, mode_nxt;
  run_mode_t           src_r, src_nxt;
  logic [POT_BITS-1:0] stored_r, stored_nxt;
  logic                active_r, active_nxt;
  logic                pseen_r, pseen_nxt;
  logic                lock_r, lock_nxt;
  logic                swl_r, swl_nxt;
  logic                sws_r, sws_nxt;

  logic [LW-1:0]       lvl_ext;
  logic [POT_BITS-1:0] lvl_sat;
  logic [POT_BITS-1:0] diff;
  logic [POT_BITS-1:0] pot_new;
  logic                above;
  act_t                want;
  origin_t             origin;
  logic                start_p, pause_p, stop_p;

  // saturate to full scale, then apply the change dead band
  assign lvl_ext = LW'(item.pot_level);
  assign lvl_sat = (lvl_ext > FULL_EXT) ? FULL : POT_BITS'(lvl_ext);
  assign diff    = (lvl_sat > stored_r) ? (lvl_sat - stored_r) : (stored_r - lvl_sat);
  assign pot_new = (diff >= POT_BITS'(change_min)) ? lvl_sat : stored_r;
  assign above   = pot_new > POT_BITS'(run_thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SES_IDLE;
      src_r    <= MODE_NONE;
      stored_r <= '0;
      active_r <= 1'b0;
      pseen_r  <= 1'b0;
      lock_r   <= 1'b0;
      swl_r    <= 1'b0;
      sws_r    <= 1'b0;
    end else if (apply) begin
      mode_r   <= mode_nxt;
      src_r    <= src_nxt;
      stored_r <= stored_nxt;
      active_r <= active_nxt;
      pseen_r  <= pseen_nxt;
      lock_r   <= lock_nxt;
      swl_r    <= swl_nxt;
      sws_r    <= sws_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    src_nxt    = src_r;
    stored_nxt = stored_r;
    active_nxt = active_r;
    pseen_nxt  = pseen_r;
    lock_nxt   = lock_r;
    swl_nxt    = swl_r;
    sws_nxt    = sws_r;
    want       = ACT_NONE;
    origin     = ORG_POT;
    start_p    = 1'b0;
    pause_p    = 1'b0;
    stop_p     = 1'b0;

    // pot: first sample only sets the baseline; edges count outside idle
    if (item.pot_valid) begin
      stored_nxt = pot_new;
      if (!pseen_r) begin
        pseen_nxt  = 1'b1;
        active_nxt = above;
      end else if (above != active_r) begin
        active_nxt = above;
        if (mode_r != SES_IDLE) begin
          if (!above) begin
            lock_nxt = 1'b0;
            want     = ACT_PAUSE;
            origin   = ORG_POT;
          end else if (!lock_r) begin
            want   = ACT_START;
            origin = ORG_POT;
          end
        end
      end
      if (mode_r == SES_RUN && above) begin
        src_nxt = MODE_POT;
      end
    end

    // footswitch: same baseline rule
    if (item.footswitch_valid) begin
      if (!sws_r) begin
        sws_nxt = 1'b1;
        swl_nxt = item.footswitch_pressed;
      end else if (swl_r != item.footswitch_pressed) begin
        swl_nxt = item.footswitch_pressed;
        if (mode_r != SES_IDLE) begin
          want     = item.footswitch_pressed ? ACT_START : ACT_PAUSE;
          origin   = ORG_SWITCH;
          lock_nxt = lock_nxt | active_nxt;
        end
      end
    end

    // UI command comes last, so it wins
    if (item.kind != ACT_NONE) begin
      want     = item.kind;
      origin   = ORG_UI;
      lock_nxt = lock_nxt | active_nxt;
    end

    unique case (want)
      ACT_STOP: begin
        mode_nxt = SES_IDLE;
        src_nxt  = MODE_NONE;
        stop_p   = 1'b1;
      end
      ACT_PAUSE: begin
        if (mode_r != SES_PAUSED) begin
          mode_nxt = SES_PAUSED;
          pause_p  = 1'b1;
        end
        src_nxt = MODE_NONE;
      end
      ACT_START: begin
        // non-UI starts are only raised outside idle
        mode_nxt = SES_RUN;
        lock_nxt = 1'b0;
        src_nxt  = (origin == ORG_POT) ? MODE_POT : MODE_MAX;
        start_p  = 1'b1;
      end
      ACT_NONE: begin
      end
    endcase

    // full scale in max mode makes the scaler return max speed exactly
    level_sel = '0;
    if (mode_nxt == SES_RUN) begin
      if (src_nxt == MODE_POT) begin
        level_sel = stored_nxt;
      end else if (src_nxt == MODE_MAX) begin
        level_sel = FULL;
      end
    end

    info.state   = mode_nxt;
    info.mode    = src_nxt;
    info.start_p = start_p;
    info.pause_p = pause_p;
    info.stop_p  = stop_p;
  end

endmodule

// ----- rtl/core/msrpc_scale.sv -----
// Speed scaler: floor(level * max_speed / full_scale) over a four-stage pipe.
`timescale 1ns / 1ps

module msrpc_scale #(
  parameter int POT_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [POT_BITS-1:0]           up_level,
  input  logic [msrpc_pkg::SPEED_W-1:0] up_max,
  input  msrpc_pkg::info_t              up_info,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [msrpc_pkg::SPEED_W-1:0] dn_speed,
  output msrpc_pkg::info_t              dn_info
);
  import msrpc_pkg::*;

  localparam int XW       = POT_BITS + SPEED_W;
  localparam int NTERM    = (XW + POT_BITS - 1) / POT_BITS;
  localparam int RW       = POT_BITS + 3;
  localparam int CW       = $clog2(NTERM + 1);
  localparam int FULL_INT = (1 << POT_BITS) - 1;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [POT_BITS-1:0] lvl1_r;
  logic [SPEED_W-1:0]  max1_r;
  logic [XW-1:0]       prod2_r;
  logic [SPEED_W-1:0]  qp3_r;
  logic [RW-1:0]       xl3_r;
  logic [SPEED_W-1:0]  speed4_r;
  info_t               info1_r, info2_r, info3_r, info4_r;

  logic [XW-1:0]       qsum;
  logic [RW-1:0]       rem;
  logic [CW-1:0]       cnt;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // x / (2^n - 1) = sum of x >> (k*n); the truncated sum falls short by at most NTERM
  always_comb begin
    qsum = '0;
    for (int k = 1; k <= NTERM; k++) begin
      qsum = qsum + (prod2_r >> (k * POT_BITS));
    end
  end

  // remainder of the partial quotient stays below (NTERM+1) * full scale
  always_comb begin
    rem = xl3_r - RW'({qp3_r, {POT_BITS{1'b0}}}) + RW'(qp3_r);
    cnt = '0;
    for (int m = 1; m <= NTERM; m++) begin
      if (rem >= RW'(m * FULL_INT)) begin
        cnt = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      lvl1_r  <= up_level;
      max1_r  <= up_max;
      info1_r <= up_info;
    end
    if (rdy2) begin
      prod2_r <= XW'(lvl1_r) * XW'(max1_r);
      info2_r <= info1_r;
    end
    if (rdy3) begin
      qp3_r   <= qsum[SPEED_W-1:0];
      xl3_r   <= prod2_r[RW-1:0];
      info3_r <= info2_r;
    end
    if (rdy4) begin
      speed4_r <= qp3_r + SPEED_W'(cnt);
      info4_r  <= info3_r;
    end
  end

  assign dn_valid = v4_r;
  assign dn_speed = speed4_r;
  assign dn_info  = info4_r;

endmodule

// ----- rtl/core/motor_session_run_pause_control.sv -----
// Top level of the motor session run/pause control.
//
//   port      dir   payload                                            role
//   in_if     sink  pot sample, footswitch level, UI command           one control tick
//   out_if    src   speed_command, session_state, run_mode, pulses     one result per tick
//   cfg_if    sink  index, data                                        register write, always ready
//
// One tick is taken every cycle while the pipe is not stalled; its result then passes
// through the input register, tick result, product, partial quotient and output register.
// The session state is updated as the tick leaves the input register.
// Reset is synchronous, active low; registers with a reset take their reset values on a
// clock edge while rst_n is low, and the pipe data registers have none. A stalled output
// holds the pipe stage by stage; ticks are still taken while any stage is empty.
`timescale 1ns / 1ps

`include "motor_session_run_pause_control_macros.svh"

module motor_session_run_pause_control #(
  parameter int POT_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  msrpc_in_if.sink           in_if,
  msrpc_out_if.source        out_if,
  msrpc_cfg_if.sink          cfg_if
);
  import msrpc_pkg::*;

  logic [SPEED_W-1:0]  max_speed_r;
  logic [THR_W-1:0]    change_min_r;
  logic [THR_W-1:0]    run_thr_r;

  logic                s0_v_r;
  item_t               s0_item_r;
  logic                up_ready;
  logic                adv;

  logic [POT_BITS-1:0] level_sel;
  info_t               tick_info;
  info_t               dn_info;
  logic [SPEED_W-1:0]  dn_speed;

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= RST_MAX_SPEED;
      change_min_r <= RST_CHANGE_MIN;
      run_thr_r    <= RST_RUN_THR;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_MAX_SPEED:  max_speed_r  <= cfg_if.data[SPEED_W-1:0];
        CFG_CHANGE_MIN: change_min_r <= cfg_if.data[THR_W-1:0];
        CFG_RUN_THR:    run_thr_r    <= cfg_if.data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign adv         = s0_v_r && up_ready;
  assign in_if.ready = !s0_v_r || up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s0_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      s0_item_r.pot_valid          <= in_if.pot_valid;
      s0_item_r.pot_level          <= in_if.pot_level;
      s0_item_r.footswitch_valid   <= in_if.footswitch_valid;
      s0_item_r.footswitch_pressed <= in_if.footswitch_pressed;
      s0_item_r.kind               <= act_t'(in_if.kind);
    end
  end

  msrpc_tick #(
    .POT_BITS (POT_BITS)
  ) u_tick (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (adv),
    .item       (s0_item_r),
    .change_min (change_min_r),
    .run_thr    (run_thr_r),
    .level_sel  (level_sel),
    .info       (tick_info)
  );

  msrpc_scale #(
    .POT_BITS (POT_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s0_v_r),
    .up_ready (up_ready),
    .up_level (level_sel),
    .up_max   (max_speed_r),
    .up_info  (tick_info),
    .dn_valid (out_if.valid),
    .dn_ready (out_if.ready),
    .dn_speed (dn_speed),
    .dn_info  (dn_info)
  );

  assign out_if.speed_command = dn_speed;
  assign out_if.session_state = dn_info.state;
  assign out_if.run_mode      = dn_info.mode;
  assign out_if.start_pulse   = dn_info.start_p;
  assign out_if.pause_pulse   = dn_info.pause_p;
  assign out_if.stop_pulse    = dn_info.stop_p;

  `MSRPC_ASSERT_NOW(a_one_pulse, clk, rst_n, out_if.valid, ($onehot0({out_if.start_pulse, out_if.pause_pulse, out_if.stop_pulse})))
  `MSRPC_ASSERT_NOW(a_speed_zero_unless_run, clk, rst_n, (out_if.valid && out_if.session_state != SES_RUN), (out_if.speed_command == '0))
  `MSRPC_ASSERT_NOW(a_mode_matches_run, clk, rst_n, out_if.valid, ((out_if.run_mode == MODE_NONE) == (out_if.session_state != SES_RUN)))
  `MSRPC_ASSERT_NOW(a_stop_goes_idle, clk, rst_n, (out_if.valid && out_if.stop_pulse), (out_if.session_state == SES_IDLE))
  `MSRPC_ASSERT_NEXT(a_s0_holds, clk, rst_n, (s0_v_r && !up_ready), (s0_v_r && $stable(s0_item_r)))

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the motor session run/pause control.
`timescale 1ns / 1ps

module tb;
  import msrpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int POT_FULL = (1 << POT_LEVEL_W) - 1;
  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    info_t              info;
  } result_t;

  logic clk;
  logic rst_n;

  msrpc_in_if  in_if();
  msrpc_out_if out_if();
  msrpc_cfg_if cfg_if();

  motor_session_run_pause_control i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Session model state and register copies
  session_t             ses;
  run_mode_t            src;
  logic [POT_LEVEL_W-1:0] pot_lvl;
  logic                 pot_act;
  logic                 pot_seen;
  logic                 rearm_lock;
  logic                 sw_lvl;
  logic                 sw_seen;
  act_t                 want_act;
  origin_t              want_org;
  logic [SPEED_W-1:0]   max_hz;
  logic [THR_W-1:0]     chg_min;
  logic [THR_W-1:0]     run_thr;

  result_t pending_results[$];
  int      errors;
  int      n_ticks;
  int      n_starts;
  int      n_pauses;
  int      n_stops;
  int      n_pot_speeds;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      last_pot;
  bit      hold_req;
  int      hold_len;
  int      hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void reset_session();
    ses        = SES_IDLE;
    src        = MODE_NONE;
    pot_lvl    = '0;
    pot_act    = 1'b0;
    pot_seen   = 1'b0;
    rearm_lock = 1'b0;
    sw_lvl     = 1'b0;
    sw_seen    = 1'b0;
    want_act   = ACT_NONE;
    want_org   = ORG_POT;
    max_hz     = RST_MAX_SPEED;
    chg_min    = RST_CHANGE_MIN;
    run_thr    = RST_RUN_THR;
  endfunction

  // Non-UI starts cannot leave idle; any non-pot intent with the pot active locks re-arm.
  function automatic void post_intent(act_t a, origin_t o);
    if (a == ACT_START && ses == SES_IDLE && o != ORG_UI) return;
    want_act = a;
    want_org = o;
    if (o != ORG_POT && pot_act) rearm_lock = 1'b1;
  endfunction

  function automatic result_t predict_tick(item_t t);
    result_t              r;
    logic [POT_LEVEL_W-1:0] lvl;
    logic [POT_LEVEL_W-1:0] delta;
    logic                 above;
    logic [63:0]          prod;
    r = '0;
    r.info.state = SES_IDLE;
    r.info.mode  = MODE_NONE;
    want_act = ACT_NONE;
    want_org = ORG_POT;
    if (t.pot_valid) begin
      lvl  = t.pot_level;
      delta = (lvl > pot_lvl) ? lvl - pot_lvl : pot_lvl - lvl;
      if (delta >= chg_min) pot_lvl = lvl;
      above = pot_lvl > run_thr;
      if (!pot_seen) begin
        pot_seen = 1'b1;
        pot_act  = above;
      end else if (above != pot_act) begin
        pot_act = above;
        if (ses != SES_IDLE) begin
          if (!above) begin
            rearm_lock = 1'b0;
            post_intent(ACT_PAUSE, ORG_POT);
          end else if (!rearm_lock) begin
            post_intent(ACT_START, ORG_POT);
          end
        end
      end
      if (ses == SES_RUN && above) src = MODE_POT;
    end
    if (t.footswitch_valid) begin
      if (!sw_seen) begin
        sw_seen = 1'b1;
        sw_lvl  = t.footswitch_pressed;
      end else if (sw_lvl != t.footswitch_pressed) begin
        sw_lvl = t.footswitch_pressed;
        if (ses != SES_IDLE) begin
          if (t.footswitch_pressed) post_intent(ACT_START, ORG_SWITCH);
          else post_intent(ACT_PAUSE, ORG_SWITCH);
        end
      end
    end
    if (t.kind != ACT_NONE) post_intent(t.kind, ORG_UI);

    case (want_act)
      ACT_STOP: begin
        ses = SES_IDLE;
        src = MODE_NONE;
        r.info.stop_p = 1'b1;
      end
      ACT_PAUSE: begin
        if (ses != SES_PAUSED) begin
          ses = SES_PAUSED;
          r.info.pause_p = 1'b1;
        end
        src = MODE_NONE;
      end
      ACT_START: begin
        if (!(ses == SES_IDLE && want_org != ORG_UI)) begin
          ses        = SES_RUN;
          rearm_lock = 1'b0;
          src        = (want_org == ORG_POT) ? MODE_POT : MODE_MAX;
          r.info.start_p = 1'b1;
        end
      end
      default: ;
    endcase

    if (ses == SES_RUN) begin
      if (src == MODE_POT) begin
        prod    = 64'(pot_lvl) * 64'(max_hz);
        r.speed = SPEED_W'(prod / 64'(POT_FULL));
      end else if (src == MODE_MAX) begin
        r.speed = max_hz;
      end
    end
    r.info.state = ses;
    r.info.mode  = src;
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 30) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [SPEED_W-1:0] got,
                             input logic [SPEED_W-1:0] want);
    if (got !== want)
      report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  // Track requests and register writes, then check each result against the oldest prediction
  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_MAX_SPEED:  max_hz  = cfg_if.data;
          CFG_CHANGE_MIN: chg_min = cfg_if.data[THR_W-1:0];
          CFG_RUN_THR:    run_thr = cfg_if.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        seen.pot_valid          = in_if.pot_valid;
        seen.pot_level          = in_if.pot_level;
        seen.footswitch_valid   = in_if.footswitch_valid;
        seen.footswitch_pressed = in_if.footswitch_pressed;
        seen.kind               = act_t'(in_if.kind);
        pending_results.push_back(predict_tick(seen));
        n_ticks++;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report("result arrived with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("speed_command", out_if.speed_command, want.speed);
          check_field("session_state", out_if.session_state, want.info.state);
          check_field("run_mode", out_if.run_mode, want.info.mode);
          check_field("start_pulse", out_if.start_pulse, want.info.start_p);
          check_field("pause_pulse", out_if.pause_pulse, want.info.pause_p);
          check_field("stop_pulse", out_if.stop_pulse, want.info.stop_p);
          if (want.info.start_p) n_starts++;
          if (want.info.pause_p) n_pauses++;
          if (want.info.stop_p) n_stops++;
          if (want.info.mode == MODE_POT && want.speed != 0) n_pot_speeds++;
        end
      end
    end
  end

  // Output ready: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic item_t mk(input logic pv, input logic [POT_LEVEL_W-1:0] lvl,
                               input logic fv, input logic fp, input act_t k);
    item_t t;
    t.pot_valid          = pv;
    t.pot_level          = lvl;
    t.footswitch_valid   = fv;
    t.footswitch_pressed = fp;
    t.kind               = k;
    return t;
  endfunction

  // Mostly plausible operator activity around the threshold, some raw noise
  function automatic item_t rand_tick();
    item_t t;
    int    lv;
    int    k;
    int    span;
    if ($urandom_range(99) < 12) begin
      t = item_t'(ITEM_W'($urandom));
    end else begin
      t.pot_valid = ($urandom_range(99) < 65);
      case ($urandom_range(9))
        0: lv = 0;
        1: lv = POT_FULL;
        2, 3: lv = int'(run_thr) + $urandom_range(4) - 2;
        4, 5, 6: begin
          span = 2 * int'(chg_min) + 3;
          lv = last_pot + $urandom_range(2 * span) - span;
        end
        default: lv = $urandom_range(POT_FULL);
      endcase
      if (lv < 0) lv = 0;
      if (lv > POT_FULL) lv = POT_FULL;
      t.pot_level          = POT_LEVEL_W'(lv);
      t.footswitch_valid   = ($urandom_range(99) < 45);
      t.footswitch_pressed = $urandom_range(1);
      k = $urandom_range(99);
      if (k < 68) t.kind = ACT_NONE;
      else if (k < 80) t.kind = ACT_START;
      else if (k < 91) t.kind = ACT_PAUSE;
      else t.kind = ACT_STOP;
    end
    if (t.pot_valid) last_pot = t.pot_level;
    return t;
  endfunction

  task automatic send_tick(input item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid              <= 1'b1;
    in_if.pot_valid          <= t.pot_valid;
    in_if.pot_level          <= t.pot_level;
    in_if.footswitch_valid   <= t.footswitch_valid;
    in_if.footswitch_pressed <= t.footswitch_pressed;
    in_if.kind               <= t.kind;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int mx, input int chg, input int thr);
    drain();
    cfg_write(CFG_MAX_SPEED, CFG_DATA_W'(mx));
    cfg_write(CFG_CHANGE_MIN, CFG_DATA_W'(chg));
    cfg_write(CFG_RUN_THR, CFG_DATA_W'(thr));
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_tick(rand_tick());
    drain();
  endtask

  // Edge handling, intent priority, re-arm lock and pause-while-paused at reset settings
  task automatic test_directed_sequences();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b1, 12'd0,    1'b1, 1'b1, ACT_NONE));   // first samples set baselines
    send_tick(mk(1'b1, 12'd4095, 1'b1, 1'b0, ACT_NONE));   // edges while idle
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_START));
    send_tick(mk(1'b1, 12'd0,    1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b1, 12'd4095, 1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b0, 12'd0,    1'b1, 1'b1, ACT_NONE));
    send_tick(mk(1'b0, 12'd0,    1'b1, 1'b0, ACT_NONE));
    send_tick(mk(1'b1, 12'd0,    1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b1, 12'd2000, 1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b1, 12'd2003, 1'b0, 1'b0, ACT_NONE));   // below change minimum
    send_tick(mk(1'b1, 12'd0,    1'b1, 1'b1, ACT_STOP));   // last intent wins
    send_tick(mk(1'b1, 12'd4095, 1'b0, 1'b0, ACT_START));
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_STOP));   // sets re-arm lock
    send_tick(mk(1'b1, 12'd0,    1'b0, 1'b0, ACT_NONE));
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_PAUSE));
    send_tick(mk(1'b1, 12'd4095, 1'b0, 1'b0, ACT_NONE));   // blocked by lock
    send_tick(mk(1'b0, 12'd0,    1'b1, 1'b0, ACT_START));
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_PAUSE));
    send_tick(mk(1'b0, 12'd0,    1'b0, 1'b0, ACT_PAUSE));
    send_tick(mk(1'b1, 12'd4095, 1'b1, 1'b1, ACT_NONE));
    send_tick(mk(1'b1, 12'hAAA,  1'b0, 1'b0, ACT_STOP));
    send_tick(mk(1'b1, 12'h555,  1'b0, 1'b0, ACT_STOP));
    drain();
  endtask

  task automatic test_unknown_register();
    drain();
    cfg_write(CFG_UNUSED, '1);
    send_tick(mk(1'b0, 12'd0, 1'b0, 1'b0, ACT_START));
    send_tick(mk(1'b0, 12'd0, 1'b0, 1'b0, ACT_STOP));
    drain();
  endtask

  task automatic test_zero_settings();
    set_regs(0, 0, 0);
    run_random(150, 0, 0);
  endtask

  task automatic test_full_settings();
    set_regs(200000, 255, 255);
    run_random(150, 62, 0);
  endtask

  task automatic test_random_settings();
    set_regs($urandom_range(200000), $urandom_range(16), $urandom_range(64));
    run_random(150, 0, 62);
    set_regs(200000, 1, 0);
    run_random(150, 14, 14);
  endtask

  // Hold the output off so the pipe fills and stalls its input, then resume
  task automatic test_output_stall();
    set_regs(RST_MAX_SPEED, RST_CHANGE_MIN, RST_RUN_THR);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_req = 1'b1;
    repeat (40) send_tick(rand_tick());
    drain();
    run_random(150, 14, 14);
  endtask

  initial begin
    errors         = 0;
    n_ticks        = 0;
    n_starts       = 0;
    n_pauses       = 0;
    n_stops        = 0;
    n_pot_speeds   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_pot       = 0;
    hold_req       = 1'b0;
    hold_len       = 0;
    hold_left      = 0;
    reset_session();
    rst_n                    = 1'b0;
    in_if.valid              = 1'b0;
    in_if.pot_valid          = 1'b0;
    in_if.pot_level          = '0;
    in_if.footswitch_valid   = 1'b0;
    in_if.footswitch_pressed = 1'b0;
    in_if.kind               = ACT_NONE;
    out_if.ready             = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.index             = CFG_MAX_SPEED;
    cfg_if.data              = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_sequences();
    test_unknown_register();
    test_zero_settings();
    test_full_settings();
    test_random_settings();
    test_output_stall();
    drain();

    $display("Checked %0d ticks over six register settings and four idle patterns,",
             n_ticks);
    $display("including %0d starts, %0d pauses, %0d stops, %0d pot-scaled speeds.",
             n_starts, n_pauses, n_stops, n_pot_speeds);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
